// File: rtl/sdq_pkg.sv
// shared types and constants of the sorted double-ended queue
package sdq_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned ACTION_W = 2;

  localparam logic signed [VALUE_W-1:0] MIN_VALUE = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT  = 2'd0,
    ACT_POP_MIN = 2'd1,
    ACT_POP_MAX = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_HEAD,
    S_POP_HEAD,
    S_POP_SHIFT,
    S_POP_TAIL,
    S_FINISH
  } state_e;

  // read address source: the read address is kept as the pointer
  typedef enum logic [2:0] {
    RD_HOLD,
    RD_TAIL,
    RD_ZERO,
    RD_ONE,
    RD_DEC,
    RD_INC
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_SHIFT_UP,
    WR_VAL_UP,
    WR_VAL_ZERO,
    WR_SHIFT_DOWN
  } wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLEAR
  } cnt_op_e;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_VAL,
    RES_RD,
    RES_MIN,
    RES_ZERO
  } res_sel_e;

  typedef struct packed {
    logic     load_in;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wr_sel_e  wr_sel;
    cnt_op_e  cnt_op;
    res_sel_e res_sel;
    status_e  res_status;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic one;
    logic rd_gt;
    logic ptr_zero;
    logic ptr_last;
  } ctrl_stat_t;

endpackage

// File: rtl/sdq_if.sv
// request and response channel interfaces of the queue

interface sdq_req_if;
  logic                                      valid;
  logic                                      ready;
  logic        [sdq_pkg::ACTION_W-1:0]       action;
  logic signed [sdq_pkg::VALUE_W-1:0]        insert_value;

  modport source (output valid, output action, output insert_value, input ready);
  modport sink   (input valid, input action, input insert_value, output ready);
endinterface

interface sdq_rsp_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [sdq_pkg::VALUE_W-1:0]        result_value;
  logic        [sdq_pkg::STATUS_W-1:0]       status;
  logic        [sdq_pkg::COUNT_W-1:0]        held_count;

  modport source (output valid, output result_value, output status, output held_count,
                  input ready);
  modport sink   (input valid, input result_value, input status, input held_count,
                  output ready);
endinterface

// File: rtl/sorted_double_ended_queue_unit.sv
// top level of the sorted double-ended queue: ascending store with pops at both ends
// one memory read and one write a cycle; an insert walks down from the tail past each held
// value greater than the new one, and a remove-smallest moves every entry above the head down
// the next transaction is taken the cycle after its result is loaded, not before
// reset clears the count and the control state; entry memory is not cleared
module sorted_double_ended_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sdq_req_if.sink     req_i,
  sdq_rsp_if.source   rsp_o
);

  sdq_pkg::ctrl_cmd_t  cmd;
  sdq_pkg::ctrl_stat_t stat;

  sdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_action_i (sdq_pkg::action_e'(req_i.action)),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_value_i   (req_i.insert_value),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_value_o  (rsp_o.result_value),
    .out_status_o (rsp_o.status),
    .out_count_o  (rsp_o.held_count)
  );

endmodule

// File: rtl/sdq_datapath.sv
// entry memory, pointer, count and result registers of the queue
module sdq_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [sdq_pkg::VALUE_W-1:0]    in_value_i,
  input  sdq_pkg::ctrl_cmd_t                    cmd_i,
  output sdq_pkg::ctrl_stat_t                   stat_o,
  output logic signed [sdq_pkg::VALUE_W-1:0]    out_value_o,
  output logic        [sdq_pkg::STATUS_W-1:0]   out_status_o,
  output logic        [sdq_pkg::COUNT_W-1:0]    out_count_o
);

  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned CW       = $clog2(DEPTH + 1);
  localparam int unsigned VW       = sdq_pkg::VALUE_W;
  localparam int unsigned OUT_CNTW = sdq_pkg::COUNT_W;

  logic signed [VW-1:0] mem_q [DEPTH];
  logic signed [VW-1:0] rd_q;
  logic        [AW-1:0] ptr_q;
  logic        [AW-1:0] raddr;
  logic        [AW-1:0] waddr;
  logic        [AW-1:0] tail;
  logic signed [VW-1:0] wdata;
  logic        [CW-1:0] count_q, count_d;
  logic signed [VW-1:0] val_q;
  logic signed [VW-1:0] res_q, res_d;
  sdq_pkg::status_e     res_status_q, res_status_d;
  logic signed [VW-1:0] out_value_q;
  sdq_pkg::status_e     out_status_q;
  logic [OUT_CNTW-1:0]  out_count_q;

  assign tail = AW'(count_q - 1'b1);

  // read address select
  always_comb begin
    case (cmd_i.rd_sel)
      sdq_pkg::RD_HOLD: raddr = ptr_q;
      sdq_pkg::RD_TAIL: raddr = tail;
      sdq_pkg::RD_ZERO: raddr = '0;
      sdq_pkg::RD_ONE:  raddr = AW'(1);
      sdq_pkg::RD_DEC:  raddr = ptr_q - 1'b1;
      sdq_pkg::RD_INC:  raddr = ptr_q + 1'b1;
      default:          raddr = ptr_q;
    endcase
  end

  // write address and data select
  always_comb begin
    case (cmd_i.wr_sel)
      sdq_pkg::WR_SHIFT_UP: begin
        waddr = ptr_q + 1'b1;
        wdata = rd_q;
      end
      sdq_pkg::WR_VAL_UP: begin
        waddr = ptr_q + 1'b1;
        wdata = val_q;
      end
      sdq_pkg::WR_VAL_ZERO: begin
        waddr = '0;
        wdata = val_q;
      end
      sdq_pkg::WR_SHIFT_DOWN: begin
        waddr = ptr_q - 1'b1;
        wdata = rd_q;
      end
      default: begin
        waddr = ptr_q;
        wdata = rd_q;
      end
    endcase
  end

  // entry memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr] <= wdata;
    end
    rd_q  <= mem_q[raddr];
    ptr_q <= raddr;
  end

  // count update
  always_comb begin
    case (cmd_i.cnt_op)
      sdq_pkg::CNT_HOLD:  count_d = count_q;
      sdq_pkg::CNT_INC:   count_d = count_q + 1'b1;
      sdq_pkg::CNT_DEC:   count_d = count_q - 1'b1;
      sdq_pkg::CNT_CLEAR: count_d = '0;
      default:            count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // result value and status of the transaction in progress
  always_comb begin
    res_status_d = res_status_q;
    case (cmd_i.res_sel)
      sdq_pkg::RES_HOLD: res_d = res_q;
      sdq_pkg::RES_VAL:  res_d = val_q;
      sdq_pkg::RES_RD:   res_d = rd_q;
      sdq_pkg::RES_MIN:  res_d = sdq_pkg::MIN_VALUE;
      sdq_pkg::RES_ZERO: res_d = '0;
      default:           res_d = res_q;
    endcase
    if (cmd_i.res_sel != sdq_pkg::RES_HOLD) begin
      res_status_d = cmd_i.res_status;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      val_q <= in_value_i;
    end
    res_q        <= res_d;
    res_status_q <= res_status_d;
    if (cmd_i.out_load) begin
      out_value_q  <= res_q;
      out_status_q <= res_status_q;
      out_count_q  <= OUT_CNTW'(count_q);
    end
  end

  // status towards the controller
  always_comb begin
    stat_o.empty    = (count_q == '0);
    stat_o.full     = (count_q == CW'(DEPTH));
    stat_o.one      = (count_q == CW'(1));
    stat_o.rd_gt    = (rd_q > val_q);
    stat_o.ptr_zero = (ptr_q == '0);
    stat_o.ptr_last = (ptr_q == tail);
  end

  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;
  assign out_count_o  = out_count_q;

endmodule

// File: rtl/sdq_ctrl.sv
// controller state machine of the queue
module sdq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  sdq_pkg::action_e      in_action_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  sdq_pkg::ctrl_stat_t   stat_i,
  output sdq_pkg::ctrl_cmd_t    cmd_o
);

  sdq_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sdq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (in_action_i)
            sdq_pkg::ACT_INSERT: begin
              if (stat_i.full) begin
                state_d = sdq_pkg::S_FINISH;
              end else if (stat_i.empty) begin
                state_d = sdq_pkg::S_INS_HEAD;
              end else begin
                state_d = sdq_pkg::S_INS_SCAN;
              end
            end
            sdq_pkg::ACT_POP_MIN: begin
              state_d = stat_i.empty ? sdq_pkg::S_FINISH : sdq_pkg::S_POP_HEAD;
            end
            sdq_pkg::ACT_POP_MAX: begin
              state_d = stat_i.empty ? sdq_pkg::S_FINISH : sdq_pkg::S_POP_TAIL;
            end
            default: state_d = sdq_pkg::S_FINISH;
          endcase
        end
      end
      sdq_pkg::S_INS_SCAN: begin
        if (!stat_i.rd_gt) begin
          state_d = sdq_pkg::S_FINISH;
        end else if (stat_i.ptr_zero) begin
          state_d = sdq_pkg::S_INS_HEAD;
        end
      end
      sdq_pkg::S_INS_HEAD: state_d = sdq_pkg::S_FINISH;
      sdq_pkg::S_POP_HEAD: begin
        state_d = stat_i.one ? sdq_pkg::S_FINISH : sdq_pkg::S_POP_SHIFT;
      end
      sdq_pkg::S_POP_SHIFT: begin
        if (stat_i.ptr_last) begin
          state_d = sdq_pkg::S_FINISH;
        end
      end
      sdq_pkg::S_POP_TAIL: state_d = sdq_pkg::S_FINISH;
      sdq_pkg::S_FINISH: begin
        if (out_free) begin
          state_d = sdq_pkg::S_IDLE;
        end
      end
      default: state_d = sdq_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o.load_in    = 1'b0;
    cmd_o.rd_sel     = sdq_pkg::RD_HOLD;
    cmd_o.wr_en      = 1'b0;
    cmd_o.wr_sel     = sdq_pkg::WR_SHIFT_UP;
    cmd_o.cnt_op     = sdq_pkg::CNT_HOLD;
    cmd_o.res_sel    = sdq_pkg::RES_HOLD;
    cmd_o.res_status = sdq_pkg::ST_OK;
    cmd_o.out_load   = 1'b0;
    case (state_q)
      sdq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          case (in_action_i)
            sdq_pkg::ACT_INSERT: begin
              cmd_o.rd_sel = sdq_pkg::RD_TAIL;
              if (stat_i.full) begin
                cmd_o.res_sel    = sdq_pkg::RES_MIN;
                cmd_o.res_status = sdq_pkg::ST_FULL;
              end
            end
            sdq_pkg::ACT_POP_MIN: begin
              cmd_o.rd_sel = sdq_pkg::RD_ZERO;
              if (stat_i.empty) begin
                cmd_o.res_sel    = sdq_pkg::RES_MIN;
                cmd_o.res_status = sdq_pkg::ST_EMPTY;
              end
            end
            sdq_pkg::ACT_POP_MAX: begin
              cmd_o.rd_sel = sdq_pkg::RD_TAIL;
              if (stat_i.empty) begin
                cmd_o.res_sel    = sdq_pkg::RES_MIN;
                cmd_o.res_status = sdq_pkg::ST_EMPTY;
              end
            end
            default: begin
              cmd_o.cnt_op  = sdq_pkg::CNT_CLEAR;
              cmd_o.res_sel = sdq_pkg::RES_ZERO;
            end
          endcase
        end
      end
      // walk down from the tail, moving greater entries up by one
      sdq_pkg::S_INS_SCAN: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.rd_gt) begin
          cmd_o.wr_sel = sdq_pkg::WR_SHIFT_UP;
          cmd_o.rd_sel = sdq_pkg::RD_DEC;
        end else begin
          cmd_o.wr_sel  = sdq_pkg::WR_VAL_UP;
          cmd_o.cnt_op  = sdq_pkg::CNT_INC;
          cmd_o.res_sel = sdq_pkg::RES_VAL;
        end
      end
      sdq_pkg::S_INS_HEAD: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = sdq_pkg::WR_VAL_ZERO;
        cmd_o.cnt_op  = sdq_pkg::CNT_INC;
        cmd_o.res_sel = sdq_pkg::RES_VAL;
      end
      sdq_pkg::S_POP_HEAD: begin
        cmd_o.res_sel = sdq_pkg::RES_RD;
        if (stat_i.one) begin
          cmd_o.cnt_op = sdq_pkg::CNT_DEC;
        end else begin
          cmd_o.rd_sel = sdq_pkg::RD_ONE;
        end
      end
      // move every entry above the head down by one
      sdq_pkg::S_POP_SHIFT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = sdq_pkg::WR_SHIFT_DOWN;
        if (stat_i.ptr_last) begin
          cmd_o.cnt_op = sdq_pkg::CNT_DEC;
        end else begin
          cmd_o.rd_sel = sdq_pkg::RD_INC;
        end
      end
      sdq_pkg::S_POP_TAIL: begin
        cmd_o.res_sel = sdq_pkg::RES_RD;
        cmd_o.cnt_op  = sdq_pkg::CNT_DEC;
      end
      sdq_pkg::S_FINISH: begin
        cmd_o.out_load = out_free;
      end
      default: begin
        cmd_o.out_load = 1'b0;
      end
    endcase
  end

  // output register valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == sdq_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: sim/sorted_double_ended_queue_unit_tb.sv
// self-checking testbench of the sorted double-ended queue: directed table, then random traffic
module sorted_double_ended_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH            = 16;
  localparam int unsigned DIR_ROWS         = 26;
  localparam int unsigned PHASES           = 4;
  localparam int unsigned SEGMENTS         = 12;
  localparam int unsigned SEGMENT_LEN      = 40;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES     = 40;
  // limit covers the slowest items in the block plus stalls and gaps on both sides
  localparam int unsigned CYCLE_LIMIT      = 400000;

  typedef struct packed {
    logic signed [sdq_pkg::VALUE_W-1:0] value;
    sdq_pkg::status_e                   status;
    logic        [sdq_pkg::COUNT_W-1:0] count;
  } sdq_result_t;

  typedef struct packed {
    sdq_pkg::action_e                   act;
    logic signed [sdq_pkg::VALUE_W-1:0] val;
    bit                                 typed;
    sdq_result_t                        want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  sdq_req_if req_if ();
  sdq_rsp_if rsp_if ();

  sorted_double_ended_queue_unit #(
    .DEPTH (DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow copy of the store, ascending
  logic signed [sdq_pkg::VALUE_W-1:0] sorted_shadow[$];
  sdq_result_t                        awaited_results[$];
  dir_row_t                           directed_rows [DIR_ROWS];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  bit          hold_rsp       = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // applies one action to the shadow store and works out its result
  function automatic sdq_result_t predict_queue_result(
      sdq_pkg::action_e act, logic signed [sdq_pkg::VALUE_W-1:0] val);
    sdq_result_t res;
    int          slot;
    res.value  = '0;
    res.status = sdq_pkg::ST_OK;
    case (act)
      sdq_pkg::ACT_INSERT: begin
        if (sorted_shadow.size() >= DEPTH) begin
          res.value  = sdq_pkg::MIN_VALUE;
          res.status = sdq_pkg::ST_FULL;
        end else begin
          // new value goes after any equal ones
          slot = 0;
          while (slot < sorted_shadow.size() && sorted_shadow[slot] <= val) slot++;
          sorted_shadow.insert(slot, val);
          res.value = val;
        end
      end
      sdq_pkg::ACT_POP_MIN, sdq_pkg::ACT_POP_MAX: begin
        if (sorted_shadow.size() == 0) begin
          res.value  = sdq_pkg::MIN_VALUE;
          res.status = sdq_pkg::ST_EMPTY;
        end else if (act == sdq_pkg::ACT_POP_MIN) begin
          res.value = sorted_shadow.pop_front();
        end else begin
          res.value = sorted_shadow.pop_back();
        end
      end
      default: begin
        sorted_shadow.delete();
      end
    endcase
    res.count = sdq_pkg::COUNT_W'(sorted_shadow.size());
    return res;
  endfunction

  // random value biased to extremes and to a narrow band that makes duplicates
  function automatic logic signed [sdq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return sdq_pkg::MIN_VALUE;
      1:       return 32'sh7fffffff;
      2, 3:    return $signed(sdq_pkg::VALUE_W'($urandom_range(8))) - 32'sd4;
      default: return $signed(sdq_pkg::VALUE_W'($urandom));
    endcase
  endfunction

  // offers one transaction, waits for acceptance, then records what must come back
  task automatic offer_action(input sdq_pkg::action_e act,
                              input logic signed [sdq_pkg::VALUE_W-1:0] val,
                              input bit typed, input sdq_result_t typed_res);
    sdq_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.insert_value <= val;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predicted = predict_queue_result(act, val);
    awaited_results.push_back(typed ? typed_res : predicted);
  endtask

  // receiver: random stalls, with one long hold-off on request
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        for (int n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clk_i);
        hold_rsp = 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    sdq_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d count=%0d", $time,
                 rsp_if.result_value, rsp_if.status, rsp_if.held_count);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (rsp_if.result_value !== want.value) begin
          $display("%0t: result_value expected %h actual %h", $time, want.value,
                   rsp_if.result_value);
          mismatch_count++;
        end
        if (rsp_if.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_if.status);
          mismatch_count++;
        end
        if (rsp_if.held_count !== want.count) begin
          $display("%0t: held_count expected %0d actual %0d", $time, want.count,
                   rsp_if.held_count);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    sdq_pkg::action_e act;
    int unsigned      ins_pct;
    int unsigned      roll;

    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.action       <= sdq_pkg::ACT_INSERT;
    req_if.insert_value <= '0;

    // empties, extremes, duplicates, a full store and clears
    directed_rows = '{
      '{sdq_pkg::ACT_POP_MIN, 32'sh12345678, 1'b1,
        '{sdq_pkg::MIN_VALUE, sdq_pkg::ST_EMPTY, 5'd0}},
      '{sdq_pkg::ACT_POP_MAX, -32'sd1,       1'b1,
        '{sdq_pkg::MIN_VALUE, sdq_pkg::ST_EMPTY, 5'd0}},
      '{sdq_pkg::ACT_CLEAR,   32'sh7fffffff, 1'b1,
        '{32'sd0,             sdq_pkg::ST_OK,    5'd0}},
      '{sdq_pkg::ACT_INSERT,  sdq_pkg::MIN_VALUE, 1'b1,
        '{sdq_pkg::MIN_VALUE, sdq_pkg::ST_OK,    5'd1}},
      '{sdq_pkg::ACT_INSERT,  32'sh7fffffff, 1'b1,
        '{32'sh7fffffff,      sdq_pkg::ST_OK,    5'd2}},
      '{sdq_pkg::ACT_INSERT,  32'sd0,        1'b1,
        '{32'sd0,             sdq_pkg::ST_OK,    5'd3}},
      '{sdq_pkg::ACT_INSERT,  -32'sd1,       1'b0, '0},
      '{sdq_pkg::ACT_INSERT,  32'sd0,        1'b0, '0},
      '{sdq_pkg::ACT_POP_MAX, 32'sd0,        1'b1,
        '{32'sh7fffffff,      sdq_pkg::ST_OK,    5'd4}},
      '{sdq_pkg::ACT_POP_MIN, 32'sd0,        1'b1,
        '{sdq_pkg::MIN_VALUE, sdq_pkg::ST_OK,    5'd3}},
      '{sdq_pkg::ACT_INSERT,  32'sh55555555, 1'b0, '0},
      '{sdq_pkg::ACT_INSERT,  32'shaaaaaaaa, 1'b0, '0},
      '{sdq_pkg::ACT_INSERT,  32'sd5,        1'b0, '0},
      '{sdq_pkg::ACT_INSERT,  -32'sd5,       1'b0, '0},
      '{sdq_pkg::ACT_INSERT,  32'sd100,      1'b0, '0},
      '{sdq_pkg::ACT_INSERT,  -32'sd100,     1'b0, '0},
      '{sdq_pkg::ACT_INSERT,  32'sd0,        1'b0, '0},
      '{sdq_pkg::ACT_INSERT,  32'sh7ffffffe, 1'b0, '0},
      '{sdq_pkg::ACT_INSERT,  32'sh80000001, 1'b0, '0},
      '{sdq_pkg::ACT_INSERT,  32'sd7,        1'b0, '0},
      '{sdq_pkg::ACT_INSERT,  32'sd7,        1'b0, '0},
      '{sdq_pkg::ACT_INSERT,  -32'sd7,       1'b0, '0},
      '{sdq_pkg::ACT_INSERT,  32'sd12345,    1'b0, '0},
      '{sdq_pkg::ACT_INSERT,  32'sd1,        1'b1,
        '{sdq_pkg::MIN_VALUE, sdq_pkg::ST_FULL,  5'd16}},
      '{sdq_pkg::ACT_POP_MIN, 32'sd0,        1'b0, '0},
      '{sdq_pkg::ACT_CLEAR,   32'sd0,        1'b1,
        '{32'sd0,             sdq_pkg::ST_OK,    5'd0}}
    };

    // reset
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[r]) begin
      offer_action(directed_rows[r].act, directed_rows[r].val, directed_rows[r].typed,
                   directed_rows[r].want);
    end

    // random traffic: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 51; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 51; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      // receiver backs off for a long stretch while items keep coming
      if (ph == 1) hold_rsp = 1'b1;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        // per segment bias so the store sweeps between empty and full
        case ($urandom_range(2))
          0:       ins_pct = 15;
          1:       ins_pct = 50;
          default: ins_pct = 85;
        endcase
        for (int k = 0; k < SEGMENT_LEN; k++) begin
          roll = $urandom_range(99);
          if (roll < 3)
            act = sdq_pkg::ACT_CLEAR;
          else if (roll < 3 + ins_pct)
            act = sdq_pkg::ACT_INSERT;
          else
            act = $urandom_range(1) ? sdq_pkg::ACT_POP_MIN : sdq_pkg::ACT_POP_MAX;
          offer_action(act, pick_value(), 1'b0, '0);
        end
      end
    end
    req_if.valid <= 1'b0;

    // drain
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
